/* design/multi_pin_edge_event_detector_defines.svh */
// Assertion macros for the multi-pin edge event detector checker.
// Depends on nothing; taken in by the checker file.
`ifndef MULTI_PIN_EDGE_EVENT_DETECTOR_DEFINES_SVH
`define MULTI_PIN_EDGE_EVENT_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MPED_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mped assertion failed");

// next-cycle implication, disabled in reset
`define MPED_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mped assertion failed");

`endif

/* design/mped_pkg.sv */
// Shared types and constants for the multi-pin edge event detector.
// No dependencies.
`default_nettype none
package mped_pkg;
  localparam int PIN_W    = 48;
  localparam int LANE_W   = 8;
  localparam int LANES    = PIN_W / LANE_W;
  localparam int NUM_W    = 6;
  localparam int LIDX_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_MASK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE = 1'd1;

  typedef struct packed {
    logic              found;
    logic [LIDX_W-1:0] idx;
    logic              rising;
  } mped_lane_t;
endpackage
`default_nettype wire

/* design/mped_lane.sv */
// One lane of eight pins: hit detection on a fresh sample and the lowest
// pending pin with its edge. Depends on mped_pkg.
`default_nettype none
module mped_lane
  import mped_pkg::*;
(
  input  wire logic [LANE_W-1:0] levels,
  input  wire logic [LANE_W-1:0] sense,
  input  wire logic [LANE_W-1:0] excl,
  input  wire logic [LANE_W-1:0] active,
  input  wire logic [LANE_W-1:0] pending,
  input  wire logic [LANE_W-1:0] held_levels,
  output logic      [LANE_W-1:0] hits,
  output mped_lane_t             result
);
  always_comb begin
    hits = ~(levels ^ sense) & ~excl & active;
    result = '0;
    for (int i = LANE_W - 1; i >= 0; i--) begin
      if (pending[i]) begin
        result.found  = 1'b1;
        result.idx    = LIDX_W'(i);
        result.rising = held_levels[i];
      end
    end
  end
endmodule
`default_nettype wire

/* design/mped_merge.sv */
// Merges lane results: picks the lowest lane that has a pending pin.
// Depends on mped_pkg.
`default_nettype none
module mped_merge
  import mped_pkg::*;
(
  input  mped_lane_t             lanes [LANES],
  output logic                   found,
  output logic       [NUM_W-1:0] pin_number,
  output logic                   edge_rising
);
  always_comb begin
    found       = 1'b0;
    pin_number  = '0;
    edge_rising = 1'b0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lanes[l].found) begin
        found       = 1'b1;
        pin_number  = NUM_W'(l * LANE_W) + NUM_W'(lanes[l].idx);
        edge_rising = lanes[l].rising;
      end
    end
  end
endmodule
`default_nettype wire

/* design/multi_pin_edge_event_detector.sv */
// Multi-pin edge event detector: one 48-pin sample per input beat, one
// output beat per edge found, in ascending pin order, tlast on the final one.
// Hits of an accepted sample are registered as the pending set, and each event beat
// is registered from that set; a sample with no events leaves the set empty. The
// next sample waits for an empty pending set, so m_tready stalls also hold it off.
// Reset (rst, synchronous): control and pending cleared, disarmed, all pins wait for low.
`default_nettype none
module multi_pin_edge_event_detector
  import mped_pkg::*;
#(
  parameter int PIN_COUNT = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [PIN_W-1:0]       s_tdata,   // [47:0] pin_levels
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // [5:0] pin_number, [6] edge_rising
  output logic                        m_tlast,   // last_event
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [PIN_W-1:0]       cfg_data
);
  localparam int ACT = (PIN_COUNT < PIN_W) ? PIN_COUNT : PIN_W;

  logic [PIN_W-1:0] exclude_mask;
  logic             detect_enable;
  logic [PIN_W-1:0] pin_sense;
  logic [PIN_W-1:0] pending;
  logic [PIN_W-1:0] held_levels;
  logic [PIN_W-1:0] active;
  logic [PIN_W-1:0] hits;
  logic [PIN_W-1:0] pending_next;
  mped_lane_t       lane_res [LANES];
  logic             found;
  logic [NUM_W-1:0] sel_pin;
  logic             sel_rising;
  logic             out_free;
  logic             accept;

  for (genvar g = 0; g < PIN_W; g++) begin : g_active
    assign active[g] = (g < ACT);
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mped_lane u_lane (
      .levels      (s_tdata[l*LANE_W +: LANE_W]),
      .sense       (pin_sense[l*LANE_W +: LANE_W]),
      .excl        (exclude_mask[l*LANE_W +: LANE_W]),
      .active      (active[l*LANE_W +: LANE_W]),
      .pending     (pending[l*LANE_W +: LANE_W]),
      .held_levels (held_levels[l*LANE_W +: LANE_W]),
      .hits        (hits[l*LANE_W +: LANE_W]),
      .result      (lane_res[l])
    );
  end

  mped_merge u_merge (
    .lanes       (lane_res),
    .found       (found),
    .pin_number  (sel_pin),
    .edge_rising (sel_rising)
  );

  assign pending_next = pending & (pending - PIN_W'(1));
  assign s_tready     = (pending == '0);
  assign accept       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      exclude_mask  <= '0;
      detect_enable <= 1'b0;
      pin_sense     <= '0;
      pending       <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept && detect_enable) begin
        pin_sense <= pin_sense ^ hits;
        pending   <= hits;
      end
      if (found && out_free) begin
        m_tvalid <= 1'b1;
        pending  <= pending_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_EXCLUDE_MASK: exclude_mask <= cfg_data;
          REG_DETECT_ENABLE: begin
            detect_enable <= cfg_data[0];
            if (cfg_data[0]) begin
              pin_sense <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_levels <= s_tdata;
    end
    if (found && out_free) begin
      m_tdata <= {1'b0, sel_rising, sel_pin};
      m_tlast <= (pending_next == '0);
    end
  end
endmodule
`default_nettype wire

/* design/mped_checker.sv */
// Port-level checker for the multi-pin edge event detector, bound to the top.
// Depends on mped_pkg and multi_pin_edge_event_detector_defines.svh.
`default_nettype none
`include "multi_pin_edge_event_detector_defines.svh"
module mped_checker
  import mped_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic [PIN_W-1:0]       s_tdata,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic                   m_tlast,
  input wire logic                   cfg_we,
  input wire logic [CFG_IDX_W-1:0]   cfg_index,
  input wire logic [PIN_W-1:0]       cfg_data
);
  logic unused;
  assign unused = s_tvalid ^ (^s_tdata) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

  // stalled beat holds
  `MPED_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // more events of the sample remain, so no new sample is taken
  `MPED_ASSERT_IMP(a_busy_mid_run, clk, rst, m_tvalid && !m_tlast, !s_tready)
  // pin number stays within the port
  `MPED_ASSERT_IMP(a_pin_range, clk, rst, m_tvalid, m_tdata[5:0] < NUM_W'(PIN_W))
  // pad bit stays clear
  `MPED_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[7] == 1'b0)
endmodule

bind multi_pin_edge_event_detector mped_checker u_mped_checker (.*);
`default_nettype wire

/* test/tb_multi_pin_edge_event_detector.sv */
// Self-checking testbench for the multi-pin edge event detector: a directed table,
// then random pin samples, checked beat by beat against an in-bench edge predictor.
// Depends on mped_pkg and the multi_pin_edge_event_detector RTL.
`default_nettype none
module tb_multi_pin_edge_event_detector;
  import mped_pkg::*;

  localparam int TB_PINS       = 48;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int GAP_PCT       = 13;
  localparam int DIR_ROWS      = 26;
  localparam int PHASES        = 10;
  localparam int PHASE_SAMPLES = 50;
  localparam int PRINT_CAP     = 200;
  localparam logic [PIN_W-1:0] ALL_PINS = {PIN_W{1'b1}};
  localparam logic [PIN_W-1:0] ONE_PIN  = {{(PIN_W-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_MASK, ROW_ARM} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [PIN_W-1:0] value;
    logic             fixed;
    logic             n_fix;
    logic [NUM_W-1:0] fix_pin;
    logic             fix_rise;
  } stim_row_t;

  typedef struct packed {
    logic [NUM_W-1:0] pin;
    logic             rising;
    logic             last;
  } edge_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [PIN_W-1:0]       s_tdata = '0;    // [47:0] pin_levels
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // [5:0] pin_number, [6] edge_rising
  logic                   m_tlast;         // last_event
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [PIN_W-1:0]       cfg_data = '0;

  multi_pin_edge_event_detector #(.PIN_COUNT(TB_PINS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [PIN_W-1:0] model_sense   = '0;
  logic [PIN_W-1:0] model_exclude = '0;
  logic             model_armed   = 1'b0;
  edge_beat_t       pending_edges[$];

  int         errors = 0;
  int         cycle = 0;
  int         samples_sent = 0;
  int         beats_seen = 0;
  int         last_beats = 0;
  int         reg_writes = 0;
  bit         no_gaps = 1'b0;
  edge_beat_t want_beat;
  logic [PIN_W-1:0] last_levels = '0;
  stim_row_t  dir_rows [DIR_ROWS];

  function automatic logic [PIN_W-1:0] live_pins();
    if (TB_PINS >= PIN_W) return ALL_PINS;
    return (ONE_PIN << TB_PINS) - ONE_PIN;
  endfunction

  function automatic logic [PIN_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[PIN_W-1:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle, msg);
  endtask

  // pins whose level equals their sense fire and flip their sense
  task automatic take_hits(input logic [PIN_W-1:0] levels, output logic [PIN_W-1:0] hits);
    hits = '0;
    if (model_armed) begin
      hits = ~(levels ^ model_sense) & ~model_exclude & live_pins();
      model_sense = model_sense ^ hits;
    end
  endtask

  task automatic queue_edges(input logic [PIN_W-1:0] levels, input logic [PIN_W-1:0] hits);
    int top;
    edge_beat_t b;
    top = -1;
    for (int p = 0; p < PIN_W; p++) if (hits[p]) top = p;
    for (int p = 0; p < PIN_W; p++) begin
      if (hits[p]) begin
        b.pin = NUM_W'(p);
        b.rising = levels[p];
        b.last = (p == top);
        pending_edges.push_back(b);
      end
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIN_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_EXCLUDE_MASK: model_exclude = data;
      REG_DETECT_ENABLE: begin
        model_armed = data[0];
        if (data[0]) model_sense = '0;
      end
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic [PIN_W-1:0] levels, input logic fixed,
                             input logic n_fix, input logic [NUM_W-1:0] fix_pin,
                             input logic fix_rise);
    logic [PIN_W-1:0] hits;
    edge_beat_t b;
    while (!no_gaps && ($urandom_range(99) < GAP_PCT)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= levels;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
    last_levels = levels;
    take_hits(levels, hits);
    if (fixed) begin
      if (n_fix) begin
        b.pin = fix_pin;
        b.rising = fix_rise;
        b.last = 1'b1;
        pending_edges.push_back(b);
      end
    end else begin
      queue_edges(levels, hits);
    end
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected", cycle,
               pending_edges.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      if (m_tlast) last_beats++;
      if (pending_edges.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat pin %0d rising %0b last %0b",
                                m_tdata[NUM_W-1:0], m_tdata[NUM_W], m_tlast));
      end else begin
        want_beat = pending_edges.pop_front();
        if (m_tdata[NUM_W-1:0] !== want_beat.pin)
          flag_mismatch($sformatf("pin_number %0d, expected %0d",
                                  m_tdata[NUM_W-1:0], want_beat.pin));
        if (m_tdata[NUM_W] !== want_beat.rising)
          flag_mismatch($sformatf("edge_rising %0b, expected %0b on pin %0d",
                                  m_tdata[NUM_W], want_beat.rising, want_beat.pin));
        if (m_tlast !== want_beat.last)
          flag_mismatch($sformatf("last_event %0b, expected %0b on pin %0d",
                                  m_tlast, want_beat.last, want_beat.pin));
      end
    end
    m_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
  end

  initial begin
    logic [PIN_W-1:0] mask;
    logic [PIN_W-1:0] levels;
    int r;

    dir_rows = '{
      '{ROW_SAMPLE, 48'h0,              1'b1, 1'b0, 6'd0,  1'b0},  // disarmed after reset
      '{ROW_SAMPLE, ALL_PINS,           1'b1, 1'b0, 6'd0,  1'b0},
      '{ROW_MASK,   48'hFFFF_FFFF_FFFE, 1'b0, 1'b0, 6'd0,  1'b0},  // pin 0 only
      '{ROW_ARM,    48'h1,              1'b0, 1'b0, 6'd0,  1'b0},
      '{ROW_SAMPLE, 48'h0,              1'b1, 1'b1, 6'd0,  1'b0},
      '{ROW_SAMPLE, 48'h0,              1'b1, 1'b0, 6'd0,  1'b0},  // now waits for high
      '{ROW_SAMPLE, ALL_PINS,           1'b1, 1'b1, 6'd0,  1'b1},
      '{ROW_MASK,   48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, 6'd0,  1'b0},  // pin 47 only
      '{ROW_SAMPLE, ALL_PINS,           1'b1, 1'b0, 6'd0,  1'b0},
      '{ROW_SAMPLE, 48'h0,              1'b1, 1'b1, 6'd47, 1'b0},
      '{ROW_SAMPLE, ALL_PINS,           1'b1, 1'b1, 6'd47, 1'b1},
      '{ROW_ARM,    48'h0,              1'b0, 1'b0, 6'd0,  1'b0},  // disarm
      '{ROW_SAMPLE, 48'h0,              1'b1, 1'b0, 6'd0,  1'b0},
      '{ROW_MASK,   48'h0,              1'b0, 1'b0, 6'd0,  1'b0},
      '{ROW_ARM,    48'h1,              1'b0, 1'b0, 6'd0,  1'b0},
      '{ROW_SAMPLE, 48'h0,              1'b0, 1'b0, 6'd0,  1'b0},  // all 48 fall
      '{ROW_SAMPLE, ALL_PINS,           1'b0, 1'b0, 6'd0,  1'b0},  // all 48 rise
      '{ROW_SAMPLE, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 6'd0,  1'b0},
      '{ROW_SAMPLE, 48'h5555_5555_5555, 1'b0, 1'b0, 6'd0,  1'b0},
      '{ROW_ARM,    48'h1,              1'b0, 1'b0, 6'd0,  1'b0},  // re-arm while armed
      '{ROW_SAMPLE, ALL_PINS,           1'b1, 1'b0, 6'd0,  1'b0},
      '{ROW_MASK,   ALL_PINS,           1'b0, 1'b0, 6'd0,  1'b0},  // everything excluded
      '{ROW_SAMPLE, 48'h0,              1'b1, 1'b0, 6'd0,  1'b0},
      '{ROW_MASK,   48'h8000_0000_0001, 1'b0, 1'b0, 6'd0,  1'b0},
      '{ROW_SAMPLE, 48'h0,              1'b0, 1'b0, 6'd0,  1'b0},
      '{ROW_SAMPLE, 48'h1234_5678_9ABC, 1'b0, 1'b0, 6'd0,  1'b0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_rows[i].kind)
        ROW_MASK: write_reg(REG_EXCLUDE_MASK, dir_rows[i].value);
        ROW_ARM:  write_reg(REG_DETECT_ENABLE, dir_rows[i].value);
        default:  send_sample(dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].n_fix,
                              dir_rows[i].fix_pin, dir_rows[i].fix_rise);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       mask = '0;
        1:       mask = ALL_PINS;
        2:       mask = rand48() & rand48();
        3:       mask = rand48();
        default: mask = rand48() & rand48() & rand48();
      endcase
      write_reg(REG_EXCLUDE_MASK, mask);
      // odd phases other than phase 5 keep the sense bits across the mask change
      if (ph == 4) write_reg(REG_DETECT_ENABLE, '0);
      else if (ph % 2 == 0 || ph == 5) write_reg(REG_DETECT_ENABLE, ONE_PIN);
      no_gaps = (ph == 6);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        r = $urandom_range(99);
        if (r < 50) begin
          levels = last_levels ^ (ONE_PIN << $urandom_range(PIN_W - 1));
          if (r < 20) levels = levels ^ (ONE_PIN << $urandom_range(PIN_W - 1));
        end else if (r < 75) begin
          levels = rand48();
        end else if (r < 85) begin
          levels = last_levels;
        end else if (r < 92) begin
          levels = '0;
        end else begin
          levels = ALL_PINS;
        end
        send_sample(levels, 1'b0, 1'b0, '0, 1'b0);
        if (ph == 2 && i == PHASE_SAMPLES / 2) settle();
      end
      no_gaps = 1'b0;
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_edges.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", pending_edges.size()));

    $display("Sent %0d pin samples over %0d register writes; checked %0d edge beats",
             samples_sent, reg_writes, beats_seen);
    $display("(%0d samples ended by tlast), with masks, disarm and re-arm, %0d mismatches",
             last_beats, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+design
design/mped_pkg.sv
design/mped_lane.sv
design/mped_merge.sv
design/multi_pin_edge_event_detector.sv
design/mped_checker.sv
test/tb_multi_pin_edge_event_detector.sv
